// ----- sv/reply_frame_receiver_defines.svh -----
// Assertion macros for the reply receiver.
`ifndef REPLY_FRAME_RECEIVER_DEFINES_SVH
`define REPLY_FRAME_RECEIVER_DEFINES_SVH

// Checked on every rising edge outside of reset.
`define RFR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checked on every rising edge, reset included.
`define RFR_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- sv/rfr_pkg.sv -----
package rfr_pkg;

  // Number of words a hunt may consume before it gives up.
  localparam int HUNT_LIMIT = 128;
  localparam logic [7:0] HUNT_LIMIT_W = 8'(HUNT_LIMIT);
  // Reply length reported when the hunt runs out, before clipping.
  localparam logic [16:0] NO_REPLY_LEN = 17'(2 * HUNT_LIMIT);

  // Frame start sequence, first word first.
  localparam logic [15:0] MAGIC_WORDS [4] = '{16'h0204, 16'h1017, 16'h0119, 16'h0117};

  // Hunt sub-steps after the four magic words.
  localparam logic [2:0] MIDX_LENGTH = 3'd4;
  localparam logic [2:0] MIDX_STATUS = 3'd5;

  localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

  // Input item kinds.
  localparam logic IK_START = 1'b0;
  localparam logic IK_WORD  = 1'b1;

  // Result item kinds.
  localparam logic RK_PAYLOAD = 1'b0;
  localparam logic RK_FINAL   = 1'b1;

  // Configuration register indexes.
  localparam logic CFG_MAX_REPLY_BYTES  = 1'b0;
  localparam logic CFG_CRC_ERROR_STATUS = 1'b1;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_HUNT,
    PH_PAYLOAD,
    PH_CRC_HI,
    PH_CRC_LO
  } phase_t;

  typedef enum logic [1:0] {
    OC_STATUS_OK,
    OC_NO_REPLY,
    OC_BAD_LENGTH,
    OC_BAD_CRC
  } outcome_t;

endpackage

// ----- sv/rfr_crc.sv -----
// CRC-32 (reflected 0xEDB88320) update over one or two bytes of a word,
// high byte first.
module rfr_crc (
  input  logic [31:0] crc_in,
  input  logic [15:0] data,
  input  logic        two_bytes,
  output logic [31:0] crc_out
);

  function automatic logic [31:0] crc_byte(input logic [31:0] acc_in, input logic [7:0] b);
    logic [31:0] acc;
    acc = acc_in ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      if (acc[0]) begin
        acc = (acc >> 1) ^ 32'hEDB8_8320;
      end else begin
        acc = acc >> 1;
      end
    end
    return acc;
  endfunction

  logic [31:0] crc_hi;

  // High byte always goes in; the low byte only for a full word.
  always_comb begin
    crc_hi  = crc_byte(crc_in, data[15:8]);
    crc_out = two_bytes ? crc_byte(crc_hi, data[7:0]) : crc_hi;
  end

endmodule

// ----- sv/reply_frame_receiver.sv -----
// Reply frame receiver. A start item (in_tuser = 0) arms a hunt for the four-word
// magic sequence; reply words (in_tuser = 1) are then parsed into length, status,
// payload and a CRC-32 trailer. Payload words come out with out_tuser = 0, and every
// finished reply ends with one outcome item (out_tuser = 1). One item is taken per
// clock unless the output stalls; an accepted word goes through an input register
// and its result then goes to the output register. The only stall is backpressure on
// the output register, which holds the input side off once both registers are full.
// Configuration writes are taken in any cycle and should only be made while idle.
`include "reply_frame_receiver_defines.svh"

module reply_frame_receiver (
  input  logic        clk,
  input  logic        rst_n,
  // Input items
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [15:0] reply_word
  input  logic        in_tuser,   // [0] kind
  // Result items
  output logic        out_tvalid,
  input  logic        out_tready,
  // [15:0] payload_word, [17:16] bytes_valid, [19:18] outcome,
  // [35:20] device_status, [51:36] reply_length, [55:52] zero
  output logic [55:0] out_tdata,
  output logic        out_tuser,  // [0] result_kind
  // Configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);

  import rfr_pkg::*;

  // Configuration registers.
  logic [15:0] max_bytes_r;
  logic [15:0] crc_err_status_r;

  // Input register.
  logic        s1_valid_r;
  logic        s1_kind_r;
  logic [15:0] s1_word_r;
  logic        s1_adv;

  // Parser state.
  phase_t      phase_r, phase_nxt;
  logic [2:0]  magic_idx_r, magic_idx_nxt;
  logic [7:0]  words_scanned_r, words_scanned_nxt;
  logic [15:0] length_r, length_nxt;
  logic [15:0] status_r, status_nxt;
  logic [15:0] bytes_rcvd_r, bytes_rcvd_nxt;
  logic [31:0] crc_r, crc_nxt;
  logic [15:0] crc_hi_r, crc_hi_nxt;

  // Output register.
  logic        out_valid_r;
  logic        out_kind_r;
  logic [15:0] out_payload_r;
  logic [1:0]  out_bytes_r;
  logic [1:0]  out_outcome_r;
  logic [15:0] out_status_r;
  logic [15:0] out_length_r;

  // Result of the current item.
  logic        emit;
  logic        res_kind;
  logic [15:0] res_payload;
  logic [1:0]  res_bytes;
  outcome_t    res_outcome;
  logic [15:0] res_status;
  logic [15:0] res_length;

  // CRC unit hookup.
  logic [31:0] crc_in;
  logic        crc_two;
  logic [31:0] crc_upd;

  // Helpers.
  logic [15:0] remain;
  logic [1:0]  valid_bytes;
  logic [15:0] bytes_sum;
  logic [7:0]  ws_inc;
  logic [16:0] len_even;
  logic [15:0] len_clip;
  logic [15:0] no_reply_len;
  logic [31:0] crc_got;

  assign cfg_ready = 1'b1;

  // Configuration write transfers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_bytes_r      <= 16'hFFFF;
      crc_err_status_r <= 16'h0000;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_MAX_REPLY_BYTES:  max_bytes_r      <= cfg_data;
        CFG_CRC_ERROR_STATUS: crc_err_status_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // The item in the input register moves on when the output register is free.
  assign s1_adv    = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_kind_r <= in_tuser;
      s1_word_r <= in_tdata;
    end
  end

  // Payload byte accounting.
  assign remain      = length_r - bytes_rcvd_r;
  assign valid_bytes = (remain >= 16'd2) ? 2'd2 : 2'd1;
  assign bytes_sum   = bytes_rcvd_r + {14'd0, valid_bytes};
  assign ws_inc      = words_scanned_r + 8'd1;
  assign len_even    = ({1'b0, length_r} + 17'd1) & ~17'd1;
  assign len_clip    = (length_r > max_bytes_r) ? max_bytes_r : length_r;
  assign no_reply_len = (NO_REPLY_LEN > {1'b0, max_bytes_r}) ? max_bytes_r
                                                               : NO_REPLY_LEN[15:0];
  assign crc_got     = {crc_hi_r, s1_word_r};

  // The length word starts the CRC afresh; payload words may carry one byte.
  assign crc_in  = (phase_r == PH_HUNT && magic_idx_r == MIDX_LENGTH) ? CRC_INIT : crc_r;
  assign crc_two = (phase_r == PH_PAYLOAD) ? (valid_bytes == 2'd2) : 1'b1;

  rfr_crc u_crc (
    .crc_in    (crc_in),
    .data      (s1_word_r),
    .two_bytes (crc_two),
    .crc_out   (crc_upd)
  );

  // Frame parser: next state and result for the item in the input register.
  always_comb begin
    phase_nxt         = phase_r;
    magic_idx_nxt     = magic_idx_r;
    words_scanned_nxt = words_scanned_r;
    length_nxt        = length_r;
    status_nxt        = status_r;
    bytes_rcvd_nxt    = bytes_rcvd_r;
    crc_nxt           = crc_r;
    crc_hi_nxt        = crc_hi_r;
    emit              = 1'b0;
    res_kind          = RK_FINAL;
    res_payload       = 16'd0;
    res_bytes         = 2'd0;
    res_outcome       = OC_STATUS_OK;
    res_status        = 16'd0;
    res_length        = 16'd0;

    if (s1_adv) begin
      if (s1_kind_r == IK_START) begin
        phase_nxt         = PH_HUNT;
        magic_idx_nxt     = 3'd0;
        words_scanned_nxt = 8'd0;
        length_nxt        = 16'd0;
        status_nxt        = 16'd0;
        bytes_rcvd_nxt    = 16'd0;
        crc_nxt           = CRC_INIT;
        crc_hi_nxt        = 16'd0;
      end else begin
        case (phase_r)
          PH_HUNT: begin
            words_scanned_nxt = ws_inc;
            if (magic_idx_r < MIDX_LENGTH) begin
              // A mismatching word is not retried as the first magic word.
              if (s1_word_r != MAGIC_WORDS[magic_idx_r[1:0]]) begin
                magic_idx_nxt = 3'd0;
              end else begin
                magic_idx_nxt = magic_idx_r + 3'd1;
              end
            end else if (magic_idx_r == MIDX_LENGTH) begin
              length_nxt    = s1_word_r;
              crc_nxt       = crc_upd;
              magic_idx_nxt = MIDX_STATUS;
            end else begin
              status_nxt = s1_word_r;
              crc_nxt    = crc_upd;
            end

            if (ws_inc >= HUNT_LIMIT_W) begin
              // Hunt ran out, even on the status word.
              emit        = 1'b1;
              res_outcome = OC_NO_REPLY;
              res_length  = no_reply_len;
              phase_nxt   = PH_IDLE;
            end else if (magic_idx_r > MIDX_LENGTH) begin
              if (len_even > {1'b0, max_bytes_r}) begin
                emit        = 1'b1;
                res_outcome = OC_BAD_LENGTH;
                res_status  = s1_word_r;
                res_length  = len_clip;
                phase_nxt   = PH_IDLE;
              end else begin
                bytes_rcvd_nxt = 16'd0;
                phase_nxt      = (length_r == 16'd0) ? PH_CRC_HI : PH_PAYLOAD;
              end
            end
          end

          PH_PAYLOAD: begin
            crc_nxt        = crc_upd;
            bytes_rcvd_nxt = bytes_sum;
            if (bytes_sum >= length_r) begin
              phase_nxt = PH_CRC_HI;
            end
            emit        = 1'b1;
            res_kind    = RK_PAYLOAD;
            res_payload = s1_word_r;
            res_bytes   = valid_bytes;
          end

          PH_CRC_HI: begin
            crc_hi_nxt = s1_word_r;
            phase_nxt  = PH_CRC_LO;
          end

          PH_CRC_LO: begin
            emit       = 1'b1;
            res_status = status_r;
            res_length = length_r;
            if (status_r != crc_err_status_r && ~crc_r != crc_got) begin
              res_outcome = OC_BAD_CRC;
            end
            phase_nxt = PH_IDLE;
          end

          default: ;
        endcase
      end
    end
  end

  // Parser state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r         <= PH_IDLE;
      magic_idx_r     <= 3'd0;
      words_scanned_r <= 8'd0;
      length_r        <= 16'd0;
      status_r        <= 16'd0;
      bytes_rcvd_r    <= 16'd0;
      crc_r           <= CRC_INIT;
      crc_hi_r        <= 16'd0;
    end else begin
      phase_r         <= phase_nxt;
      magic_idx_r     <= magic_idx_nxt;
      words_scanned_r <= words_scanned_nxt;
      length_r        <= length_nxt;
      status_r        <= status_nxt;
      bytes_rcvd_r    <= bytes_rcvd_nxt;
      crc_r           <= crc_nxt;
      crc_hi_r        <= crc_hi_nxt;
    end
  end

  // Output register: loaded on each advance, emptied by a transfer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= emit;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_kind_r    <= res_kind;
      out_payload_r <= res_payload;
      out_bytes_r   <= res_bytes;
      out_outcome_r <= res_outcome;
      out_status_r  <= res_status;
      out_length_r  <= res_length;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_kind_r;
  assign out_tdata  = {4'd0, out_length_r, out_status_r, out_outcome_r, out_bytes_r,
                       out_payload_r};

  // Checks on the parser.
  `RFR_ASSERT(a_payload_bytes, (out_valid_r && out_kind_r == RK_PAYLOAD) |-> (out_bytes_r == 2'd1 || out_bytes_r == 2'd2), "payload result without valid bytes")
  `RFR_ASSERT(a_result_source, $rose(out_valid_r) |-> $past(s1_valid_r), "result appeared with no item in the input register")
  `RFR_ASSERT(a_payload_count, (phase_r == PH_PAYLOAD) |-> (bytes_rcvd_r < length_r), "payload phase with all bytes already received")
  `RFR_ASSERT_ALWAYS(a_hunt_count, (phase_r == PH_HUNT) |-> (words_scanned_r < HUNT_LIMIT_W), "hunt continued past its word limit")

endmodule

// ----- bench/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;
  import rfr_pkg::*;

  // One result item, unpacked from tdata and tuser.
  typedef struct packed {
    logic        rkind;
    logic [15:0] payload_word;
    logic [1:0]  bytes_valid;
    logic [1:0]  outcome;
    logic [15:0] device_status;
    logic [15:0] reply_length;
  } reply_result_t;

  // One input item as it waits in the stimulus queue.
  typedef struct packed {
    logic        kind;
    logic [15:0] word;
  } reply_item_t;

  localparam int unsigned DRAIN_CYCLES = 12;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = '0;
  logic        in_tuser = IK_START;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [55:0] out_tdata;
  logic        out_tuser;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_index = CFG_MAX_REPLY_BYTES;
  logic [15:0] cfg_data = '0;

  reply_frame_receiver uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #2 clk = ~clk;

  // Stimulus waiting to be driven and results waiting to be seen.
  reply_item_t   pending_items[$];
  reply_result_t expected_results[$];

  int unsigned send_idle_pct = 10;
  int unsigned recv_idle_pct = 60;
  logic        in_fire = 1'b0;

  int unsigned mismatch_count = 0;
  int unsigned stim_count = 0;
  int unsigned inputs_accepted = 0;
  int unsigned payload_checked = 0;
  int unsigned outcome_checked[4] = '{0, 0, 0, 0};

  // Receiver state as predicted from the accepted items.
  logic [15:0] buf_capacity;
  logic [15:0] crc_err_status;
  phase_t      rx_phase;
  logic [2:0]  magic_pos;
  logic [7:0]  scan_count;
  logic [15:0] len_word;
  logic [15:0] status_word;
  logic [15:0] byte_count;
  logic [31:0] crc_acc;
  logic [15:0] crc_hi;

  // Reflected CRC-32, one byte at a time.
  function automatic logic [31:0] crc32_byte(logic [31:0] acc, logic [7:0] b);
    logic [31:0] c;
    c = acc ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ 32'hEDB8_8320) : (c >> 1);
    end
    return c;
  endfunction

  // A word feeds the CRC high byte first.
  function automatic logic [31:0] crc32_word(logic [31:0] acc, logic [15:0] w);
    return crc32_byte(crc32_byte(acc, w[15:8]), w[7:0]);
  endfunction

  function automatic logic [15:0] clip_to_buffer(logic [16:0] v);
    return (v > {1'b0, buf_capacity}) ? buf_capacity : v[15:0];
  endfunction

  function automatic void clear_reply_state();
    rx_phase = PH_IDLE;
    magic_pos = '0;
    scan_count = '0;
    len_word = '0;
    status_word = '0;
    byte_count = '0;
    crc_acc = CRC_INIT;
    crc_hi = '0;
  endfunction

  function automatic void post_outcome(logic [1:0] oc, logic [15:0] st, logic [15:0] len);
    reply_result_t r;
    r = '0;
    r.rkind = RK_FINAL;
    r.outcome = oc;
    r.device_status = st;
    r.reply_length = len;
    expected_results.push_back(r);
    rx_phase = PH_IDLE;
  endfunction

  // Advance the predicted receiver by one accepted item.
  function automatic void predict_reply_item(logic kind, logic [15:0] w);
    reply_result_t r;
    logic          got_status;
    logic [16:0]   rounded;
    logic [15:0]   remain;
    logic [1:0]    nbytes;
    got_status = 1'b0;
    if (kind == IK_START) begin
      clear_reply_state();
      rx_phase = PH_HUNT;
      return;
    end
    case (rx_phase)
      PH_HUNT: begin
        if (magic_pos < MIDX_LENGTH) begin
          // A mismatch restarts the hunt without retrying this word.
          if (w != MAGIC_WORDS[magic_pos[1:0]]) magic_pos = '0;
          else magic_pos = magic_pos + 3'd1;
        end else if (magic_pos == MIDX_LENGTH) begin
          len_word = w;
          crc_acc = crc32_word(CRC_INIT, w);
          magic_pos = MIDX_STATUS;
        end else begin
          status_word = w;
          crc_acc = crc32_word(crc_acc, w);
          got_status = 1'b1;
        end
        scan_count = scan_count + 8'd1;
        if (scan_count >= HUNT_LIMIT_W) begin
          post_outcome(OC_NO_REPLY, 16'd0, clip_to_buffer(NO_REPLY_LEN));
        end else if (got_status) begin
          rounded = ({1'b0, len_word} + 17'd1) & 17'h1_FFFE;
          if (rounded > {1'b0, buf_capacity}) begin
            post_outcome(OC_BAD_LENGTH, status_word, clip_to_buffer({1'b0, len_word}));
          end else begin
            byte_count = '0;
            if (len_word == 16'd0) rx_phase = PH_CRC_HI;
            else rx_phase = PH_PAYLOAD;
          end
        end
      end
      PH_PAYLOAD: begin
        remain = len_word - byte_count;
        nbytes = (remain >= 16'd2) ? 2'd2 : 2'd1;
        crc_acc = crc32_byte(crc_acc, w[15:8]);
        if (nbytes == 2'd2) crc_acc = crc32_byte(crc_acc, w[7:0]);
        byte_count = byte_count + 16'(nbytes);
        if (byte_count >= len_word) rx_phase = PH_CRC_HI;
        r = '0;
        r.rkind = RK_PAYLOAD;
        r.payload_word = w;
        r.bytes_valid = nbytes;
        expected_results.push_back(r);
      end
      PH_CRC_HI: begin
        crc_hi = w;
        rx_phase = PH_CRC_LO;
      end
      PH_CRC_LO: begin
        // A device that saw a CRC error of its own is not checked.
        if (status_word != crc_err_status && ~crc_acc != {crc_hi, w})
          post_outcome(OC_BAD_CRC, status_word, len_word);
        else
          post_outcome(OC_STATUS_OK, status_word, len_word);
      end
      default: begin
      end
    endcase
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    mismatch_count++;
    if (mismatch_count <= 40)
      $display("MISMATCH at %0t ns: %s got 0x%0h, wanted 0x%0h", $realtime, what, got, want);
  endtask

  // Sample both channels at the rising edge; predict on each input transfer and
  // check each result transfer against the oldest expectation.
  always @(posedge clk) begin : monitor
    reply_result_t want;
    in_fire = 1'b0;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        in_fire = 1'b1;
        inputs_accepted++;
        predict_reply_item(in_tuser, in_tdata);
      end
      if (out_tvalid && out_tready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("result with none expected, tdata", {8'd0, out_tdata}, 64'd0);
        end else begin
          want = expected_results.pop_front();
          if (out_tuser !== want.rkind)
            report_mismatch("result_kind", 64'(out_tuser), 64'(want.rkind));
          if (out_tdata[15:0] !== want.payload_word)
            report_mismatch("payload_word", 64'(out_tdata[15:0]), 64'(want.payload_word));
          if (out_tdata[17:16] !== want.bytes_valid)
            report_mismatch("bytes_valid", 64'(out_tdata[17:16]), 64'(want.bytes_valid));
          if (out_tdata[19:18] !== want.outcome)
            report_mismatch("outcome", 64'(out_tdata[19:18]), 64'(want.outcome));
          if (out_tdata[35:20] !== want.device_status)
            report_mismatch("device_status", 64'(out_tdata[35:20]),
                            64'(want.device_status));
          if (out_tdata[51:36] !== want.reply_length)
            report_mismatch("reply_length", 64'(out_tdata[51:36]), 64'(want.reply_length));
          if (out_tdata[55:52] !== 4'd0)
            report_mismatch("tdata padding", 64'(out_tdata[55:52]), 64'd0);
          if (want.rkind == RK_FINAL) outcome_checked[want.outcome]++;
          else payload_checked++;
        end
      end
    end
  end

  // Drive the next item at the falling edge once the previous one has been taken.
  always @(negedge clk) begin : driver
    reply_item_t next_item;
    if (rst_n) begin
      if (!in_tvalid || in_fire) begin
        if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          next_item = pending_items.pop_front();
          in_tvalid <= 1'b1;
          in_tdata <= next_item.word;
          in_tuser <= next_item.kind;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic push_item(input logic kind, input logic [15:0] w);
    reply_item_t it;
    it.kind = kind;
    it.word = w;
    pending_items.push_back(it);
    stim_count++;
  endtask

  function automatic logic [15:0] noise_word();
    if ($urandom_range(3) == 0) return MAGIC_WORDS[$urandom_range(3)];
    return 16'($urandom);
  endfunction

  // Build the words of one reply after its start item. Payload is only built
  // when the length fits the buffer; the trailer is sent either way.
  task automatic build_frame(input int unsigned garbage, input logic [15:0] len,
                             input logic [15:0] status, input bit corrupt,
                             ref logic [15:0] words[$]);
    logic [31:0] crc;
    logic [16:0] rounded;
    logic [15:0] w;
    int unsigned nwords;
    words.delete();
    repeat (garbage) words.push_back(noise_word());
    for (int k = 0; k < 4; k++) words.push_back(MAGIC_WORDS[k]);
    words.push_back(len);
    words.push_back(status);
    crc = crc32_word(crc32_word(CRC_INIT, len), status);
    rounded = ({1'b0, len} + 17'd1) & 17'h1_FFFE;
    if (rounded <= {1'b0, buf_capacity}) begin
      nwords = 32'(rounded / 2);
      for (int unsigned k = 0; k < nwords; k++) begin
        w = 16'($urandom);
        if (k == nwords - 1 && len[0]) crc = crc32_byte(crc, w[15:8]);
        else crc = crc32_word(crc, w);
        words.push_back(w);
      end
    end
    crc = ~crc;
    if (corrupt) crc = crc ^ (32'd1 << $urandom_range(31));
    words.push_back(crc[31:16]);
    words.push_back(crc[15:0]);
  endtask

  task automatic push_frame(input int unsigned garbage, input logic [15:0] len,
                            input logic [15:0] status, input bit corrupt);
    logic [15:0] words[$];
    build_frame(garbage, len, status, corrupt, words);
    push_item(IK_START, 16'($urandom));
    foreach (words[k]) push_item(IK_WORD, words[k]);
  endtask

  task automatic push_exhausted_hunt();
    push_item(IK_START, 16'($urandom));
    repeat (HUNT_LIMIT) push_item(IK_WORD, noise_word());
  endtask

  // Mostly small lengths, some around the buffer size, a few far beyond it.
  function automatic logic [15:0] pick_length();
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 60) return 16'($urandom_range(24));
    if (sel < 75) return 16'($urandom_range(120, 25));
    if (sel < 90 && buf_capacity <= 16'd400)
      return 16'($urandom_range(buf_capacity + 1, (buf_capacity == 0) ? 0 : buf_capacity - 1));
    if (buf_capacity == 16'hFFFF) return 16'hFFFF;
    return 16'($urandom_range(65535, buf_capacity + 1));
  endfunction

  task automatic run_random_items(input int unsigned target);
    int unsigned first;
    int unsigned pick;
    int unsigned n;
    logic [15:0] status;
    logic [15:0] words[$];
    first = stim_count;
    if (buf_capacity < 16'd256) begin
      push_exhausted_hunt();
    end
    while (stim_count - first < target) begin
      pick = $urandom_range(99);
      status = ($urandom_range(4) == 0) ? crc_err_status : 16'($urandom);
      if (pick < 72) begin
        // Well-formed reply, now and then with noise ahead of the magic.
        n = ($urandom_range(3) == 0) ? $urandom_range(8, 1) : 0;
        push_frame(n, pick_length(), status, $urandom_range(4) == 0);
      end else if (pick < 85) begin
        // Reply cut short; the next start arrives while it is busy.
        build_frame(0, 16'($urandom_range(20)), status, 1'b0, words);
        push_item(IK_START, 16'($urandom));
        n = $urandom_range(words.size() - 1, 1);
        for (int unsigned k = 0; k < n; k++) push_item(IK_WORD, words[k]);
      end else if (pick < 95) begin
        // Stray words; ignored unless a reply is still in progress.
        n = $urandom_range(3, 1);
        repeat (n) push_item(IK_WORD, noise_word());
        first += n;
      end else if (pick < 99) begin
        // Start followed by a short burst of noise only.
        push_item(IK_START, 16'($urandom));
        repeat ($urandom_range(20, 1)) push_item(IK_WORD, noise_word());
      end else begin
        push_exhausted_hunt();
      end
    end
  endtask

  task automatic wait_until_drained();
    while (pending_items.size() != 0 || in_tvalid || expected_results.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input logic idx, input logic [15:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == CFG_MAX_REPLY_BYTES) buf_capacity = value;
    else crc_err_status = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_registers(input logic [15:0] capacity, input logic [15:0] err_status);
    write_register(CFG_MAX_REPLY_BYTES, capacity);
    write_register(CFG_CRC_ERROR_STATUS, err_status);
  endtask

  // Stimulus sequence: directed replies, then random phases across several
  // register settings and idle patterns.
  initial begin : stimulus
    logic [15:0] words[$];
    buf_capacity = 16'hFFFF;
    crc_err_status = 16'h0000;
    clear_reply_state();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Words before any start are ignored.
    push_item(IK_WORD, MAGIC_WORDS[0]);
    push_item(IK_WORD, 16'hFFFF);
    // Zero length, odd single byte, bad CRC, length beyond any buffer.
    push_frame(0, 16'd0, 16'h0000, 1'b0);
    push_frame(0, 16'd1, 16'hFFFF, 1'b0);
    push_frame(0, 16'd3, 16'h5AA5, 1'b1);
    push_frame(0, 16'hFFFF, 16'h8001, 1'b0);
    // Status equal to the error status skips the CRC check.
    push_frame(0, 16'd2, 16'h0000, 1'b1);
    // A repeated first magic word is not retried as a new first word.
    push_frame(5, 16'd2, 16'h1234, 1'b0);
    pending_items[pending_items.size() - 14].word = MAGIC_WORDS[0];
    pending_items[pending_items.size() - 13].word = MAGIC_WORDS[0];
    pending_items[pending_items.size() - 12].word = MAGIC_WORDS[1];
    pending_items[pending_items.size() - 11].word = MAGIC_WORDS[2];
    pending_items[pending_items.size() - 10].word = MAGIC_WORDS[3];
    // Start while a reply is in its payload.
    build_frame(0, 16'd6, 16'h00FF, 1'b0, words);
    push_item(IK_START, 16'h0000);
    for (int k = 0; k < 8; k++) push_item(IK_WORD, words[k]);
    push_frame(0, 16'd4, 16'hFF00, 1'b0);
    // Hunt runs out, once on noise and once on the status word itself.
    push_item(IK_START, 16'hFFFF);
    repeat (HUNT_LIMIT) push_item(IK_WORD, 16'hFFFF);
    push_item(IK_START, 16'h0000);
    repeat (HUNT_LIMIT - 6) push_item(IK_WORD, 16'h0000);
    for (int k = 0; k < 4; k++) push_item(IK_WORD, MAGIC_WORDS[k]);
    push_item(IK_WORD, 16'd2);
    push_item(IK_WORD, 16'h4321);
    wait_until_drained();

    // Sender idles lightly, receiver heavily.
    send_idle_pct = 10;
    recv_idle_pct = 60;
    set_registers(16'd0, 16'hFFFF);
    run_random_items(40);
    wait_until_drained();
    set_registers(16'd16, 16'($urandom));
    run_random_items(40);
    wait_until_drained();

    // The other way round.
    send_idle_pct = 60;
    recv_idle_pct = 10;
    set_registers(16'hFFFF, 16'h0000);
    run_random_items(40);
    wait_until_drained();
    set_registers(16'($urandom_range(400, 1)), 16'($urandom));
    run_random_items(40);
    wait_until_drained();

    // Neither side idles.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_registers(16'hFFFF, 16'hFFFF);
    run_random_items(40);
    wait_until_drained();
    set_registers(16'd301, 16'h0000);
    run_random_items(40);
    wait_until_drained();

    $display("Accepted %0d input transfers; checked %0d payload words and %0d outcomes",
             inputs_accepted, payload_checked,
             outcome_checked[0] + outcome_checked[1] + outcome_checked[2] +
             outcome_checked[3]);
    $display("Outcomes: %0d status valid, %0d no reply, %0d bad length, %0d bad CRC",
             outcome_checked[OC_STATUS_OK], outcome_checked[OC_NO_REPLY],
             outcome_checked[OC_BAD_LENGTH], outcome_checked[OC_BAD_CRC]);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Watchdog for a hung handshake or results that never arrive.
  initial begin : watchdog
    #2_000_000;
    $display("Timeout with %0d results still expected", expected_results.size());
    $display("Mismatches found");
    $finish;
  end

endmodule
